// ----- rtl/sas_pkg.sv -----
// Package for the sprite animation sequencer: sizes, opcodes, state
// encoding and the request/response words of the remainder unit.
// No dependencies.
`default_nettype none
package sas_pkg;

  localparam int MAX_SUBSEQUENCES = 16;
  localparam int MAX_FRAMES       = 64;
  localparam int DURATION_BITS    = 16;

  localparam int SUB_W     = $clog2(MAX_SUBSEQUENCES);
  localparam int FRM_W     = $clog2(MAX_FRAMES);
  localparam int FT_DEPTH  = MAX_SUBSEQUENCES * MAX_FRAMES;
  localparam int FT_W      = DURATION_BITS + 1;
  localparam int ST_DEPTH  = MAX_SUBSEQUENCES;
  localparam int ST_W      = 8;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 5;
  localparam int OP_W      = 3;
  localparam int SIDX_W    = 8;
  localparam int FIDX_W    = 6;
  localparam int ELAPSED_W = 32;

  // remainder unit sizes
  localparam int REM_DVD_W  = 8;
  localparam int REM_DIV_W  = 7;
  localparam int REM_STEP_W = $clog2(REM_DVD_W);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_RESTART = 3'd1,
    OP_SEL_SUB = 3'd2,
    OP_SEL_FRM = 3'd3,
    OP_WR_SUB  = 3'd4,
    OP_WR_FRM  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REM,
    ST_FRD,
    ST_FAPPLY,
    ST_OUT
  } sas_state_t;

  typedef struct packed {
    logic                 start;
    logic [REM_DVD_W-1:0] dividend;
    logic [REM_DIV_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [REM_DIV_W-1:0] rem;
  } rem_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/sas_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module sas_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/sas_rem.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on sas_pkg.
`default_nettype none
module sas_rem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sas_pkg::rem_req_t req,
  output sas_pkg::rem_rsp_t      rsp
);
  import sas_pkg::*;

  logic                  run_r;
  logic                  done_r;
  logic [REM_STEP_W-1:0] cnt_r;
  logic [REM_DVD_W-1:0]  dvd_r;
  logic [REM_DIV_W-1:0]  div_r;
  logic [REM_DIV_W-1:0]  rem_r;
  logic [REM_DIV_W:0]    shifted;
  logic [REM_DIV_W:0]    diff;
  logic [REM_DIV_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[REM_DVD_W-1]};
    diff    = shifted - {1'b0, div_r};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = diff[REM_DIV_W-1:0];
    end else begin
      rem_nxt = shifted[REM_DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= REM_STEP_W'(REM_DVD_W - 1);
        dvd_r <= req.dividend;
        div_r <= req.divisor;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[REM_DVD_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ----- rtl/sprite_animation_sequencer_unit.sv -----
// Sprite animation sequencer: playback control over subsequence and frame tables.
// A tick that stays in its frame, table writes, unused ops and an out-of-range frame select
// go straight to the output; restart and a frame select first read the frame table; a tick
// that steps the frame or a subsequence select runs one 8-step remainder pass first, and a
// tick that also moves on runs a second pass for the subsequence. Busy holds until the strobe
// ends, and results are never stalled. Reset clears playback and sets the count to 1.
`default_nettype none
module sprite_animation_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sas_pkg::OP_W-1:0]       in_op,
  input  wire logic                           in_ignore_loop,
  input  wire logic [sas_pkg::SIDX_W-1:0]     in_subsequence_index,
  input  wire logic [sas_pkg::FIDX_W-1:0]     in_frame_index,
  input  wire logic [sas_pkg::DURATION_BITS-1:0] in_frame_duration,
  input  wire logic                           in_frame_has_image,
  input  wire logic [sas_pkg::CNT_W-1:0]      in_frames_in_subsequence,
  input  wire logic                           in_subsequence_looped,
  output logic                                out_valid,
  output logic [sas_pkg::FRM_W-1:0]           out_current_frame,
  output logic [sas_pkg::SUB_W-1:0]           out_current_subsequence,
  output logic [sas_pkg::DURATION_BITS-1:0]   out_time_in_frame,
  output logic [sas_pkg::DURATION_BITS-1:0]   out_active_duration,
  output logic [sas_pkg::ELAPSED_W-1:0]       out_elapsed_ticks,
  output logic                                out_done_res,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sas_pkg::CFG_W-1:0]      cfg_subsequence_count
);
  import sas_pkg::*;

  sas_state_t state_r, state_nxt;

  // latched command word
  logic [OP_W-1:0]          op_r;
  logic                     ign_r;
  logic [SIDX_W-1:0]        sidx_r;
  logic [FIDX_W-1:0]        fidx_r;
  logic [DURATION_BITS-1:0] dur_in_r;
  logic                     img_r;
  logic [CNT_W-1:0]         nfr_r;
  logic                     lp_r;

  // playback state
  logic [CFG_W-1:0]         sub_cnt_r;
  logic [FRM_W-1:0]         frame_r, frame_nxt;
  logic [SUB_W-1:0]         sub_r, sub_nxt;
  logic [DURATION_BITS-1:0] timer_r, timer_nxt;
  logic [DURATION_BITS-1:0] dur_r, dur_nxt;
  logic [ELAPSED_W-1:0]     elapsed_r, elapsed_nxt;
  logic                     done_r, done_nxt;
  logic                     chain_r, chain_nxt;
  logic                     rem_sub_r, rem_sub_nxt;

  // memories
  logic                          ft_we;
  logic [$clog2(FT_DEPTH)-1:0]   ft_waddr;
  logic [FT_W-1:0]               ft_wdata;
  logic [FT_W-1:0]               ft_q;
  logic                          st_we;
  logic [SUB_W-1:0]              st_waddr;
  logic [ST_W-1:0]               st_wdata;
  logic [ST_W-1:0]               st_q;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic [REM_DIV_W-1:0]     eff_fc;
  logic [REM_DIV_W-1:0]     eff_sc;
  logic [DURATION_BITS-1:0] timer_inc;
  logic [SUB_W:0]           sub_plus;

  sas_ram #(.DEPTH(FT_DEPTH), .WIDTH(FT_W)) u_frame_mem (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .raddr ({sub_r, frame_r}),
    .rdata (ft_q)
  );

  sas_ram #(.DEPTH(ST_DEPTH), .WIDTH(ST_W)) u_sub_mem (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (sub_r),
    .rdata (st_q)
  );

  sas_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // effective counts: zero acts as one, clamp at the table size
  always_comb begin
    if (st_q[CNT_W-1:0] == '0) begin
      eff_fc = REM_DIV_W'(1);
    end else if (st_q[CNT_W-1:0] > CNT_W'(MAX_FRAMES)) begin
      eff_fc = REM_DIV_W'(MAX_FRAMES);
    end else begin
      eff_fc = REM_DIV_W'(st_q[CNT_W-1:0]);
    end
    if (sub_cnt_r == '0) begin
      eff_sc = REM_DIV_W'(1);
    end else if (sub_cnt_r > CFG_W'(MAX_SUBSEQUENCES)) begin
      eff_sc = REM_DIV_W'(MAX_SUBSEQUENCES);
    end else begin
      eff_sc = REM_DIV_W'(sub_cnt_r);
    end
  end

  assign timer_inc = (timer_r == '1) ? timer_r : timer_r + 1'b1;
  assign sub_plus  = {1'b0, sub_r} + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_TICK: begin
            state_nxt = (timer_inc >= dur_r) ? ST_REM : ST_OUT;
          end
          OP_RESTART: state_nxt = ST_FRD;
          OP_SEL_SUB: state_nxt = ST_REM;
          OP_SEL_FRM: begin
            state_nxt = ({1'b0, fidx_r} < eff_fc) ? ST_FRD : ST_OUT;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_REM: begin
        if (rem_rsp.done) begin
          state_nxt = ST_FRD;
        end
      end
      ST_FRD:    state_nxt = ST_FAPPLY;
      ST_FAPPLY: state_nxt = chain_r ? ST_REM : ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    frame_nxt        = frame_r;
    sub_nxt          = sub_r;
    timer_nxt        = timer_r;
    dur_nxt          = dur_r;
    elapsed_nxt      = elapsed_r;
    done_nxt         = done_r;
    chain_nxt        = chain_r;
    rem_sub_nxt      = rem_sub_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = '0;
    rem_req.divisor  = eff_sc;
    ft_we            = 1'b0;
    ft_waddr         = {sidx_r[SUB_W-1:0], fidx_r[FRM_W-1:0]};
    ft_wdata         = {img_r, dur_in_r};
    st_we            = 1'b0;
    st_waddr         = sidx_r[SUB_W-1:0];
    st_wdata         = {lp_r, nfr_r};
    busy             = (state_r != ST_IDLE);
    out_valid        = (state_r == ST_OUT);
    cfg_ready        = 1'b1;

    case (state_r)
      ST_EXEC: begin
        done_nxt  = 1'b0;
        chain_nxt = 1'b0;
        case (op_r)
          OP_TICK: begin
            elapsed_nxt = elapsed_r + 1'b1;
            timer_nxt   = timer_inc;
            if (timer_inc >= dur_r) begin
              rem_req.start    = 1'b1;
              rem_req.dividend = REM_DVD_W'({1'b0, frame_r} + 1'b1);
              rem_req.divisor  = eff_fc;
              rem_sub_nxt      = 1'b0;
            end
          end
          OP_RESTART: begin
            sub_nxt     = '0;
            frame_nxt   = '0;
            elapsed_nxt = '0;
          end
          OP_SEL_SUB: begin
            rem_req.start    = 1'b1;
            rem_req.dividend = sidx_r;
            rem_sub_nxt      = 1'b1;
          end
          OP_SEL_FRM: begin
            if ({1'b0, fidx_r} < eff_fc) begin
              frame_nxt = fidx_r[FRM_W-1:0];
            end
          end
          OP_WR_SUB: begin
            st_we = (sidx_r[SIDX_W-1:SUB_W] == '0);
          end
          OP_WR_FRM: begin
            ft_we = (sidx_r[SIDX_W-1:SUB_W] == '0);
          end
          default: ;
        endcase
      end
      ST_REM: begin
        if (rem_rsp.done) begin
          if (rem_sub_r) begin
            // land on a subsequence; done when it is the first one
            sub_nxt   = rem_rsp.rem[SUB_W-1:0];
            frame_nxt = '0;
            if (rem_rsp.rem[SUB_W-1:0] != sub_r) begin
              elapsed_nxt = '0;
            end
            if (rem_rsp.rem[SUB_W-1:0] == '0) begin
              elapsed_nxt = '0;
              done_nxt    = 1'b1;
            end
          end else begin
            frame_nxt = rem_rsp.rem[FRM_W-1:0];
            chain_nxt = (rem_rsp.rem[FRM_W-1:0] == '0) && (!st_q[ST_W-1] || ign_r);
          end
        end
      end
      ST_FAPPLY: begin
        if (ft_q[FT_W-1]) begin
          timer_nxt = '0;
          dur_nxt   = ft_q[DURATION_BITS-1:0];
        end
        if (chain_r) begin
          chain_nxt        = 1'b0;
          rem_req.start    = 1'b1;
          rem_req.dividend = REM_DVD_W'(sub_plus);
          rem_sub_nxt      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sub_cnt_r <= CFG_W'(1);
      frame_r   <= '0;
      sub_r     <= '0;
      timer_r   <= '0;
      dur_r     <= '0;
      elapsed_r <= '0;
      done_r    <= 1'b0;
      chain_r   <= 1'b0;
      rem_sub_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      frame_r   <= frame_nxt;
      sub_r     <= sub_nxt;
      timer_r   <= timer_nxt;
      dur_r     <= dur_nxt;
      elapsed_r <= elapsed_nxt;
      done_r    <= done_nxt;
      chain_r   <= chain_nxt;
      rem_sub_r <= rem_sub_nxt;
      if (cfg_valid && cfg_ready) begin
        sub_cnt_r <= cfg_subsequence_count;
      end
    end
  end

  // hold the command word for the whole operation
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= in_op;
      ign_r    <= in_ignore_loop;
      sidx_r   <= in_subsequence_index;
      fidx_r   <= in_frame_index;
      dur_in_r <= in_frame_duration;
      img_r    <= in_frame_has_image;
      nfr_r    <= in_frames_in_subsequence;
      lp_r     <= in_subsequence_looped;
    end
  end

  assign out_current_frame       = frame_r;
  assign out_current_subsequence = sub_r;
  assign out_time_in_frame       = timer_r;
  assign out_active_duration     = dur_r;
  assign out_elapsed_ticks       = elapsed_r;
  assign out_done_res            = done_r;

endmodule
`default_nettype wire

// ----- tb/sv/tb_sprite_animation_sequencer_unit.sv -----
// Self-checking testbench for sprite_animation_sequencer_unit: table loads, playback
// ops, count register settings and a long frame timer run, checked against a predictor.
// Depends on sas_pkg and the sequencer RTL only.
`default_nettype none
module tb_sprite_animation_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_WORDS   = 960;
  localparam int LONG_TICKS     = 200;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic [DURATION_BITS-1:0] DUR_SAT = '1;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic                     ign;
    logic [SIDX_W-1:0]        sidx;
    logic [FIDX_W-1:0]        fidx;
    logic [DURATION_BITS-1:0] dur;
    logic                     img;
    logic [CNT_W-1:0]         nfr;
    logic                     looped;
  } anim_word_t;

  typedef struct {
    logic [FRM_W-1:0]         frame;
    logic [SUB_W-1:0]         sub;
    logic [DURATION_BITS-1:0] timer;
    logic [DURATION_BITS-1:0] dur;
    logic [ELAPSED_W-1:0]     elapsed;
    logic                     done;
  } anim_status_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0]          in_op = '0;
  logic                     in_ignore_loop = 1'b0;
  logic [SIDX_W-1:0]        in_subsequence_index = '0;
  logic [FIDX_W-1:0]        in_frame_index = '0;
  logic [DURATION_BITS-1:0] in_frame_duration = '0;
  logic                     in_frame_has_image = 1'b0;
  logic [CNT_W-1:0]         in_frames_in_subsequence = '0;
  logic                     in_subsequence_looped = 1'b0;
  logic                     out_valid;
  logic [FRM_W-1:0]         out_current_frame;
  logic [SUB_W-1:0]         out_current_subsequence;
  logic [DURATION_BITS-1:0] out_time_in_frame;
  logic [DURATION_BITS-1:0] out_active_duration;
  logic [ELAPSED_W-1:0]     out_elapsed_ticks;
  logic                     out_done_res;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_subsequence_count = '0;

  sprite_animation_sequencer_unit u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_op                    (in_op),
    .in_ignore_loop           (in_ignore_loop),
    .in_subsequence_index     (in_subsequence_index),
    .in_frame_index           (in_frame_index),
    .in_frame_duration        (in_frame_duration),
    .in_frame_has_image       (in_frame_has_image),
    .in_frames_in_subsequence (in_frames_in_subsequence),
    .in_subsequence_looped    (in_subsequence_looped),
    .out_valid                (out_valid),
    .out_current_frame        (out_current_frame),
    .out_current_subsequence  (out_current_subsequence),
    .out_time_in_frame        (out_time_in_frame),
    .out_active_duration      (out_active_duration),
    .out_elapsed_ticks        (out_elapsed_ticks),
    .out_done_res             (out_done_res),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_subsequence_count    (cfg_subsequence_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Playback predictor state
  logic [FT_W-1:0]          frame_mem [FT_DEPTH];
  logic [ST_W-1:0]          seq_mem [ST_DEPTH];
  bit                       frame_loaded [FT_DEPTH];
  logic [CFG_W-1:0]         seq_count = CFG_W'(1);
  logic [FRM_W-1:0]         pl_frame = '0;
  logic [SUB_W-1:0]         pl_sub = '0;
  logic [DURATION_BITS-1:0] pl_timer = '0;
  logic [DURATION_BITS-1:0] pl_dur = '0;
  logic [ELAPSED_W-1:0]     pl_elapsed = '0;

  anim_status_t status_q [$];
  int words_sent = 0;
  int status_checked = 0;
  int done_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int count_settings = 0;
  bit start_drv = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;

  function automatic int live_seq_count();
    int c;
    c = int'(seq_count);
    if (c == 0) c = 1;
    if (c > MAX_SUBSEQUENCES) c = MAX_SUBSEQUENCES;
    return c;
  endfunction

  function automatic int frames_of(logic [CNT_W-1:0] n);
    int c;
    c = int'(n);
    if (c == 0) c = 1;
    if (c > MAX_FRAMES) c = MAX_FRAMES;
    return c;
  endfunction

  // Entering an image frame restarts its timing; a frame without one keeps it
  function automatic void load_frame();
    logic [FT_W-1:0] e;
    e = frame_mem[{pl_sub, pl_frame}];
    if (e[DURATION_BITS]) begin
      pl_timer = '0;
      pl_dur   = e[DURATION_BITS-1:0];
    end
  endfunction

  function automatic logic jump_to_seq(int target);
    logic [SUB_W-1:0] prev;
    prev   = pl_sub;
    pl_sub = SUB_W'(target % live_seq_count());
    if (prev != pl_sub) pl_elapsed = '0;
    pl_frame = '0;
    load_frame();
    if (pl_sub == '0) begin
      pl_elapsed = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic anim_status_t advance_playback(anim_word_t w);
    anim_status_t s;
    logic done;
    done = 1'b0;
    case (w.op)
      OP_TICK: begin
        pl_elapsed = pl_elapsed + 1'b1;
        if (pl_timer != DUR_SAT) pl_timer = pl_timer + 1'b1;
        if (pl_timer >= pl_dur) begin
          pl_frame = FRM_W'((int'(pl_frame) + 1) % frames_of(seq_mem[pl_sub][CNT_W-1:0]));
          load_frame();
          if (pl_frame == '0 && (!seq_mem[pl_sub][ST_W-1] || w.ign))
            done = jump_to_seq(int'(pl_sub) + 1);
        end
      end
      OP_RESTART: begin
        pl_sub     = '0;
        pl_elapsed = '0;
        pl_frame   = '0;
        load_frame();
      end
      OP_SEL_SUB: done = jump_to_seq(int'(w.sidx));
      OP_SEL_FRM: begin
        if (int'(w.fidx) < frames_of(seq_mem[pl_sub][CNT_W-1:0])) begin
          pl_frame = w.fidx;
          load_frame();
        end
      end
      OP_WR_SUB: begin
        if (w.sidx < MAX_SUBSEQUENCES) seq_mem[w.sidx[SUB_W-1:0]] = {w.looped, w.nfr};
      end
      OP_WR_FRM: begin
        if (w.sidx < MAX_SUBSEQUENCES) begin
          frame_mem[{w.sidx[SUB_W-1:0], w.fidx}]    = {w.img, w.dur};
          frame_loaded[{w.sidx[SUB_W-1:0], w.fidx}] = 1'b1;
        end
      end
      default: ;
    endcase
    s.frame   = pl_frame;
    s.sub     = pl_sub;
    s.timer   = pl_timer;
    s.dur     = pl_dur;
    s.elapsed = pl_elapsed;
    s.done    = done;
    return s;
  endfunction

  function automatic anim_word_t mk_word(logic [OP_W-1:0] op, int sidx = 0, int fidx = 0,
                                         int dur = 0, bit img = 1'b0, int nfr = 1,
                                         bit looped = 1'b0, bit ign = 1'b0);
    anim_word_t w;
    w.op     = op;
    w.sidx   = SIDX_W'(sidx);
    w.fidx   = FIDX_W'(fidx);
    w.dur    = DURATION_BITS'(dur);
    w.img    = img;
    w.nfr    = CNT_W'(nfr);
    w.looped = looped;
    w.ign    = ign;
    return w;
  endfunction

  // Mostly short durations so frames turn over; now and then any value
  function automatic logic [DURATION_BITS-1:0] rand_duration();
    if ($urandom_range(0, 11) == 0) return DURATION_BITS'($urandom);
    return DURATION_BITS'($urandom_range(0, 6));
  endfunction

  function automatic anim_word_t make_random_word();
    anim_word_t w;
    int r;
    r        = $urandom_range(0, 99);
    w.ign    = 1'($urandom_range(0, 1));
    w.sidx   = SIDX_W'($urandom_range(0, 255));
    w.fidx   = FIDX_W'($urandom_range(0, 63));
    w.dur    = rand_duration();
    w.img    = 1'($urandom_range(0, 1));
    w.nfr    = ($urandom_range(0, 15) == 0) ? CNT_W'($urandom_range(0, 127))
                                            : CNT_W'($urandom_range(1, 6));
    w.looped = 1'($urandom_range(0, 1));
    if (r < 50) w.op = OP_TICK;
    else if (r < 55) w.op = OP_RESTART;
    else if (r < 64) w.op = OP_SEL_SUB;
    else if (r < 74) w.op = OP_SEL_FRM;
    else if (r < 81) w.op = OP_WR_SUB;
    else if (r < 97) w.op = OP_WR_FRM;
    else w.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    if ((w.op == OP_WR_SUB || w.op == OP_WR_FRM) && $urandom_range(0, 9) != 0)
      w.sidx = SIDX_W'($urandom_range(0, 15));
    if (w.op == OP_SEL_SUB && $urandom_range(0, 1) == 0) w.sidx = SIDX_W'($urandom_range(0, 20));
    if (w.op == OP_SEL_FRM && $urandom_range(0, 2) != 0) w.fidx = FIDX_W'($urandom_range(0, 7));
    return w;
  endfunction

  task automatic hold_off(int n);
    if (n == 0) return;
    if (start_drv) begin
      start <= 1'b0;
      start_drv = 1'b0;
    end
    repeat (n) @(posedge clk);
  endtask

  // Burst pacing: after a burst, mostly drop start for a random gap
  task automatic pace();
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
  endtask

  task automatic send_word(anim_word_t w);
    start                    <= 1'b1;
    in_op                    <= w.op;
    in_ignore_loop           <= w.ign;
    in_subsequence_index     <= w.sidx;
    in_frame_index           <= w.fidx;
    in_frame_duration        <= w.dur;
    in_frame_has_image       <= w.img;
    in_frames_in_subsequence <= w.nfr;
    in_subsequence_looped    <= w.looped;
    start_drv = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    status_q.push_back(advance_playback(w));
    words_sent++;
    pace();
  endtask

  // Write every frame a subsequence of this count can reach and that is not yet loaded, before it is used
  task automatic fill_frames(int sub, logic [CNT_W-1:0] n);
    for (int f = 0; f < frames_of(n); f++)
      if (!frame_loaded[sub * MAX_FRAMES + f])
        send_word(mk_word(OP_WR_FRM, sub, f, rand_duration(), 1'($urandom_range(0, 1))));
  endtask

  task automatic send_random_word();
    anim_word_t w;
    w = make_random_word();
    if (w.op == OP_WR_SUB && w.sidx < MAX_SUBSEQUENCES) fill_frames(int'(w.sidx), w.nfr);
    send_word(w);
  endtask

  task automatic wait_idle();
    if (start_drv) begin
      start <= 1'b0;
      start_drv = 1'b0;
    end
    while (status_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_count(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_valid             <= 1'b1;
    cfg_subsequence_count <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    seq_count = v;
    count_settings++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : status_check
    anim_status_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status word with none expected: expected nothing, got frame %0h",
                   $time, out_current_frame);
      end else begin
        want = status_q.pop_front();
        status_checked++;
        if (want.done) done_seen++;
        check_field("current_frame", 32'(want.frame), 32'(out_current_frame));
        check_field("current_subsequence", 32'(want.sub), 32'(out_current_subsequence));
        check_field("time_in_frame", 32'(want.timer), 32'(out_time_in_frame));
        check_field("active_duration", 32'(want.dur), 32'(out_active_duration));
        check_field("elapsed_ticks", want.elapsed, out_elapsed_ticks);
        check_field("done_res", 32'(want.done), 32'(out_done_res));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Load every subsequence entry, the last one at full length
  task automatic test_table_load();
    int n;
    for (int s = 0; s < MAX_SUBSEQUENCES; s++) begin
      n = (s == MAX_SUBSEQUENCES - 1) ? MAX_FRAMES : $urandom_range(1, 4);
      fill_frames(s, CNT_W'(n));
      send_word(mk_word(OP_WR_SUB, s, 0, 0, 1'b0, n, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_directed_ops();
    send_word(mk_word(OP_TICK));
    send_word(mk_word(OP_TICK, 0, 0, 0, 1'b0, 1, 1'b0, 1'b1));
    send_word(mk_word(OP_TICK, 0, 0, 0, 1'b0, 1, 1'b0, 1'b1));
    send_word(mk_word(OP_RESTART));
    send_word(mk_word(OP_SEL_SUB, 255));
    send_word(mk_word(OP_SEL_FRM, 0, 63));
    send_word(mk_word(OP_SEL_FRM, 0, 0));
    send_word(mk_word(OP_SPARE_6, 255, 63, 16'hFFFF, 1'b1, 127, 1'b1, 1'b1));
    send_word(mk_word(OP_SPARE_7));
    send_word(mk_word(OP_WR_SUB, 16, 0, 0, 1'b0, 3, 1'b1));
    send_word(mk_word(OP_WR_SUB, 255, 0, 0, 1'b0, 127, 1'b1));
    send_word(mk_word(OP_WR_FRM, 255, 63, 16'hFFFF, 1'b1));
    send_word(mk_word(OP_WR_FRM, 15, 63, 16'hFFFF, 1'b1));
    // zero count acts as one, oversized count as the maximum
    send_word(mk_word(OP_WR_SUB, 14, 0, 0, 1'b0, 0, 1'b1));
    send_word(mk_word(OP_WR_SUB, 15, 0, 0, 1'b0, 127, 1'b0));
    set_count(CFG_W'(MAX_SUBSEQUENCES));
    send_word(mk_word(OP_SEL_SUB, 15));
    send_word(mk_word(OP_SEL_FRM, 0, 63));
    send_word(mk_word(OP_TICK));
    send_word(mk_word(OP_SEL_FRM, 0, 62));
    send_word(mk_word(OP_TICK, 0, 0, 0, 1'b0, 1, 1'b0, 1'b1));
    send_word(mk_word(OP_TICK));
    send_word(mk_word(OP_SEL_SUB, 16));
    send_word(mk_word(OP_SEL_SUB, 14));
    send_word(mk_word(OP_TICK, 0, 0, 0, 1'b0, 1, 1'b0, 1'b1));
    send_word(mk_word(OP_TICK));
  endtask

  // Zero and oversized counts, then the normal extremes
  task automatic test_count_extremes();
    logic [CFG_W-1:0] settings [5] = '{5'd0, 5'd31, 5'd17, 5'd16, 5'd1};
    foreach (settings[i]) begin
      set_count(settings[i]);
      send_word(mk_word(OP_SEL_SUB, 255));
      repeat (15) send_random_word();
    end
  endtask

  // Hold an image frame of maximum duration and tick back to back without a frame step
  task automatic test_timer_saturation();
    set_count(CFG_W'(1));
    send_word(mk_word(OP_WR_FRM, 0, 0, 16'hFFFF, 1'b1));
    send_word(mk_word(OP_WR_FRM, 0, 1, 5, 1'b0));
    send_word(mk_word(OP_WR_SUB, 0, 0, 0, 1'b0, 2, 1'b1));
    send_word(mk_word(OP_RESTART));
    steady = 1'b1;
    repeat (LONG_TICKS) send_word(mk_word(OP_TICK));
    steady = 1'b0;
  endtask

  task automatic test_random_playback();
    logic [CFG_W-1:0] settings [8] = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd2, 5'd12, 5'd1, 5'd16};
    int stop_at;
    foreach (settings[i]) begin
      set_count((i == 5) ? CFG_W'($urandom_range(0, 31)) : settings[i]);
      stop_at = words_sent + RANDOM_WORDS / 8;
      while (words_sent < stop_at) send_random_word();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed_ops();
    test_count_extremes();
    test_timer_saturation();
    test_random_playback();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (status_q.size() != 0) begin
      mismatches++;
      $display("%0t: status words missing: expected %0d more, got 0", $time, status_q.size());
    end
    $display("Covered %0d words over %0d count settings, including a long back to back tick run.",
             words_sent, count_settings);
    $display("Checked %0d status words, %0d with done set; %0d mismatches.",
             status_checked, done_seen, mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
